[rtl/core/tsdr_pkg.sv]
// Shared types and constants for the tile store with dirty rectangle tracking.
`default_nettype none

package tsdr_pkg;

   localparam int MAX_COLS_DEF  = 64;
   localparam int MAX_ROWS_DEF  = 64;
   localparam int TILE_BITS_DEF = 16;

   // Grid size after reset; the dirty rectangle starts as the whole grid.
   localparam logic [6:0] GRID_RESET = 7'd64;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_READ  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      CSR_GRID_WIDTH   = 2'd0,
      CSR_GRID_HEIGHT  = 2'd1,
      CSR_DEFAULT_TILE = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_EXEC,
      ST_ROW
   } state_type;

endpackage

`default_nettype wire

[rtl/core/tile_store_dirty_rectangle_top.sv]
// Tile map store that tracks one dirty bounding rectangle over the grid.
//
// Request channel (req_*): one item per operation: write tile, read tile or
// clear dirty, with a signed column and row and a tile value. Response channel
// (rsp_*): one item per request with the tile read (zero unless a read) and
// the dirty flag and rectangle as they stand after the operation.
// CSR port (csr_*): grid width, grid height and default tile, to be written only
// while no request is in flight; the block itself does not enforce this.
// Sequence: a request is accepted in the idle state, which also issues the
// tile RAM read; the execute state then compares, writes and updates the
// column extent of the rectangle. A write that changes a tile goes on to the
// row state, in which the same min/extent unit updates the row extent. A new
// request is accepted only in the idle state, so an item is through execute
// (and row) before the next one is taken; the RAM read is registered.
// Reset: the tile RAM is swept to zero, one entry per cycle, over all
// MAX_COLS*MAX_ROWS entries while req_ready stays low; CSR writes are taken.
// Stall: the response sits in an output register; the next request is still
// accepted, and it holds in its execute cycle until the response is taken.
`default_nettype none

module tile_store_dirty_rectangle_top
   import tsdr_pkg::*;
#(
   parameter int MAX_COLS  = MAX_COLS_DEF,
   parameter int MAX_ROWS  = MAX_ROWS_DEF,
   parameter int TILE_BITS = TILE_BITS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,

   input  wire logic              req_valid,
   output      logic              req_ready,
   input  wire logic [1:0]        req_operation,
   input  wire logic signed [7:0] req_col,
   input  wire logic signed [7:0] req_row,
   input  wire logic [15:0]       req_new_tile,

   output      logic              rsp_valid,
   input  wire logic              rsp_ready,
   output      logic [15:0]       rsp_read_value,
   output      logic              rsp_is_dirty,
   output      logic [5:0]        rsp_rect_left,
   output      logic [5:0]        rsp_rect_top,
   output      logic [6:0]        rsp_rect_cols,
   output      logic [6:0]        rsp_rect_rows,

   input  wire logic              csr_write_en,
   input  wire logic [1:0]        csr_index,
   input  wire logic [15:0]       csr_wdata
);

   localparam int DEPTH   = MAX_COLS * MAX_ROWS;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int MAX_DIM = (MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS;
   localparam int POS_W   = $clog2(MAX_DIM);
   localparam int LEN_W   = ($clog2(MAX_DIM + 1) > 7) ? $clog2(MAX_DIM + 1) : 7;
   localparam int SUM_W   = LEN_W + 1;

   // configuration
   logic [6:0]           grid_width_ff, grid_height_ff;
   logic [TILE_BITS-1:0] default_tile_ff;

   // control and tracking state
   state_type            state_ff, state_in;
   logic [ADDR_W-1:0]    sweep_ff, sweep_in;
   logic                 dirty_ff, dirty_in;
   logic [POS_W-1:0]     box_left_ff, box_left_in, box_top_ff, box_top_in;
   logic [LEN_W-1:0]     box_cols_ff, box_cols_in, box_rows_ff, box_rows_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [15:0]          read_value_ff, read_value_in;

   // captured request
   op_type               op_ff;
   logic                 hit_ff;
   logic [ADDR_W-1:0]    addr_ff;
   logic [POS_W-1:0]     col_ff, row_ff;
   logic [TILE_BITS-1:0] tile_ff;

   // tile RAM
   logic                 ram_wr_en, ram_rd_en;
   logic [ADDR_W-1:0]    ram_wr_addr, ram_rd_addr;
   logic [TILE_BITS-1:0] ram_wr_data, ram_rd_data;

   tsdr_ram #(
      .WIDTH (TILE_BITS),
      .DEPTH (DEPTH)
   ) u_tile_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // request decode: range check against the saturated grid size
   logic [8:0]        eff_width, eff_height;
   logic              req_hit;
   logic              req_fire;
   logic              out_free;

   assign eff_width  = (9'(grid_width_ff) > 9'(MAX_COLS)) ? 9'(MAX_COLS) : 9'(grid_width_ff);
   assign eff_height = (9'(grid_height_ff) > 9'(MAX_ROWS)) ? 9'(MAX_ROWS)
                                                          : 9'(grid_height_ff);
   assign req_hit = !req_col[7] && !req_row[7]
                 && (9'(req_col[6:0]) < eff_width) && (9'(req_row[6:0]) < eff_height);
   assign ram_rd_addr = ADDR_W'(req_row[6:0]) * ADDR_W'(MAX_COLS) + ADDR_W'(req_col[6:0]);
   assign req_fire = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // shared min/extent unit: column axis in EXEC, row axis in ROW
   logic [POS_W-1:0] ext_lo, ext_pos, ext_lo_new;
   logic [LEN_W-1:0] ext_len, ext_len_new;
   logic [SUM_W-1:0] ext_hi, ext_end, ext_hi_max;

   always_comb begin
      if (state_ff == ST_ROW) begin
         ext_lo  = box_top_ff;
         ext_len = box_rows_ff;
         ext_pos = row_ff;
      end else begin
         ext_lo  = box_left_ff;
         ext_len = box_cols_ff;
         ext_pos = col_ff;
      end
      ext_hi     = SUM_W'(ext_lo) + SUM_W'(ext_len);
      ext_end    = SUM_W'(ext_pos) + SUM_W'(1);
      ext_hi_max = (ext_end > ext_hi) ? ext_end : ext_hi;
      if (!dirty_ff) begin
         // clean store: the rectangle starts as this single cell
         ext_lo_new  = ext_pos;
         ext_len_new = LEN_W'(1);
      end else begin
         ext_lo_new  = (ext_pos < ext_lo) ? ext_pos : ext_lo;
         ext_len_new = LEN_W'(ext_hi_max - SUM_W'(ext_lo_new));
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      sweep_in      = sweep_ff;
      dirty_in      = dirty_ff;
      box_left_in   = box_left_ff;
      box_top_in    = box_top_ff;
      box_cols_in   = box_cols_ff;
      box_rows_in   = box_rows_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      read_value_in = read_value_ff;
      req_ready     = 1'b0;
      ram_rd_en     = 1'b0;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = addr_ff;
      ram_wr_data   = tile_ff;

      case (state_ff)
         ST_SWEEP: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = sweep_ff;
            ram_wr_data = '0;
            sweep_in    = sweep_ff + ADDR_W'(1);
            if (sweep_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            ram_rd_en = req_valid;
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // hold until the output register is free
            if (out_free) begin
               read_value_in = '0;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
               case (op_ff)
                  OP_WRITE: begin
                     if (hit_ff && (ram_rd_data != tile_ff)) begin
                        ram_wr_en    = 1'b1;
                        box_left_in  = ext_lo_new;
                        box_cols_in  = ext_len_new;
                        rsp_valid_in = 1'b0;
                        state_in     = ST_ROW;
                     end
                  end
                  OP_READ: begin
                     read_value_in = hit_ff ? 16'(ram_rd_data) : 16'(default_tile_ff);
                  end
                  OP_CLEAR: begin
                     dirty_in    = 1'b0;
                     box_left_in = '0;
                     box_top_in  = '0;
                     box_cols_in = '0;
                     box_rows_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_ROW: begin
            if (out_free) begin
               box_top_in    = ext_lo_new;
               box_rows_in   = ext_len_new;
               dirty_in      = 1'b1;
               read_value_in = '0;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         sweep_ff     <= '0;
         dirty_ff     <= 1'b1;
         box_left_ff  <= '0;
         box_top_ff   <= '0;
         box_cols_ff  <= LEN_W'(GRID_RESET);
         box_rows_ff  <= LEN_W'(GRID_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         dirty_ff     <= dirty_in;
         box_left_ff  <= box_left_in;
         box_top_ff   <= box_top_in;
         box_cols_ff  <= box_cols_in;
         box_rows_ff  <= box_rows_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      read_value_ff <= read_value_in;
      if (req_fire) begin
         op_ff   <= op_type'(req_operation);
         hit_ff  <= req_hit;
         addr_ff <= ram_rd_addr;
         col_ff  <= POS_W'(req_col[6:0]);
         row_ff  <= POS_W'(req_row[6:0]);
         tile_ff <= TILE_BITS'(req_new_tile);
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff   <= GRID_RESET;
         grid_height_ff  <= GRID_RESET;
         default_tile_ff <= '0;
      end else if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_GRID_WIDTH:   grid_width_ff   <= csr_wdata[6:0];
            CSR_GRID_HEIGHT:  grid_height_ff  <= csr_wdata[6:0];
            CSR_DEFAULT_TILE: default_tile_ff <= TILE_BITS'(csr_wdata);
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = read_value_ff;
   assign rsp_is_dirty   = dirty_ff;
   assign rsp_rect_left  = 6'(box_left_ff);
   assign rsp_rect_top   = 6'(box_top_ff);
   assign rsp_rect_cols  = 7'(box_cols_ff);
   assign rsp_rect_rows  = 7'(box_rows_ff);

   // an accepted item always moves to its execute cycle
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == ST_EXEC)
      else $error("accepted item did not enter execute");

   // a response only appears after an execute or row update step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_EXEC || $past(state_ff) == ST_ROW))
      else $error("response raised outside execute");

   // a clean store carries an empty rectangle, except midway through a first write
   a_clean_empty: assert property (@(posedge clock) disable iff (reset)
      (!dirty_ff && state_ff != ST_ROW) |-> (box_cols_ff == '0 && box_rows_ff == '0))
      else $error("clean store with nonempty rectangle");

   // a dirty store never carries an empty rectangle
   a_dirty_nonempty: assert property (@(posedge clock) disable iff (reset)
      dirty_ff |-> (box_cols_ff != '0 && box_rows_ff != '0))
      else $error("dirty store with empty rectangle");

endmodule

`default_nettype wire

[rtl/core/tsdr_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module tsdr_ram
   import tsdr_pkg::*;
#(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
// Self-checking testbench for the tile store with dirty rectangle tracking.
module testbench
   import tsdr_pkg::*;
();

   localparam int CLK_PERIOD       = 20;
   localparam int GRID_MAX         = 64;
   localparam int RUN_LIMIT_CYCLES = 1_000_000;
   localparam int SETTLE_CYCLES    = 8;
   localparam int REPORT_LIMIT     = 10;

   typedef struct packed {
      logic [15:0] read_value;
      logic        is_dirty;
      logic [5:0]  rect_left;
      logic [5:0]  rect_top;
      logic [6:0]  rect_cols;
      logic [6:0]  rect_rows;
   } tile_status_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [1:0]        req_operation;
   logic signed [7:0] req_col;
   logic signed [7:0] req_row;
   logic [15:0]       req_new_tile;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [15:0]       rsp_read_value;
   logic              rsp_is_dirty;
   logic [5:0]        rsp_rect_left;
   logic [5:0]        rsp_rect_top;
   logic [6:0]        rsp_rect_cols;
   logic [6:0]        rsp_rect_rows;
   logic              csr_write_en;
   logic [1:0]        csr_index;
   logic [15:0]       csr_wdata;

   // Shadow copy of the tile map, the dirty box and the registers.
   logic [15:0]  tile_shadow [0:GRID_MAX*GRID_MAX-1];
   logic         dirty_shadow;
   int           box_left;
   int           box_top;
   int           box_cols;
   int           box_rows;
   logic [6:0]   cfg_width;
   logic [6:0]   cfg_height;
   logic [15:0]  cfg_default;

   tile_status_type expected_status [$];
   int           fail_count;
   int           send_idle_pct;
   int           recv_stall_pct;

   tile_store_dirty_rectangle_top DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_operation  (req_operation),
      .req_col        (req_col),
      .req_row        (req_row),
      .req_new_tile   (req_new_tile),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_read_value (rsp_read_value),
      .rsp_is_dirty   (rsp_is_dirty),
      .rsp_rect_left  (rsp_rect_left),
      .rsp_rect_top   (rsp_rect_top),
      .rsp_rect_cols  (rsp_rect_cols),
      .rsp_rect_rows  (rsp_rect_rows),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   function automatic bit in_grid(int c, int r);
      int w;
      int h;
      w = (cfg_width > GRID_MAX) ? GRID_MAX : int'(cfg_width);
      h = (cfg_height > GRID_MAX) ? GRID_MAX : int'(cfg_height);
      return c >= 0 && c < w && r >= 0 && r < h;
   endfunction

   function automatic tile_status_type apply_tile_op(op_type op, logic signed [7:0] col,
                                                     logic signed [7:0] row, logic [15:0] tile);
      int c;
      int r;
      int hi_x;
      int hi_y;
      tile_status_type st;
      c  = col;
      r  = row;
      st = '0;
      case (op)
         OP_WRITE: begin
            if (in_grid(c, r) && tile_shadow[r*GRID_MAX+c] != tile) begin
               tile_shadow[r*GRID_MAX+c] = tile;
               if (!dirty_shadow) begin
                  // A clean store starts the box as the single cell.
                  dirty_shadow = 1'b1;
                  box_left     = c;
                  box_top      = r;
                  box_cols     = 1;
                  box_rows     = 1;
               end else begin
                  hi_x     = (c + 1 > box_left + box_cols) ? c + 1 : box_left + box_cols;
                  hi_y     = (r + 1 > box_top + box_rows) ? r + 1 : box_top + box_rows;
                  box_left = (c < box_left) ? c : box_left;
                  box_top  = (r < box_top) ? r : box_top;
                  box_cols = hi_x - box_left;
                  box_rows = hi_y - box_top;
               end
            end
         end
         OP_READ: begin
            st.read_value = in_grid(c, r) ? tile_shadow[r*GRID_MAX+c] : cfg_default;
         end
         OP_CLEAR: begin
            dirty_shadow = 1'b0;
            box_left     = 0;
            box_top      = 0;
            box_cols     = 0;
            box_rows     = 0;
         end
         default: ;
      endcase
      st.is_dirty  = dirty_shadow;
      st.rect_left = box_left[5:0];
      st.rect_top  = box_top[5:0];
      st.rect_cols = box_cols[6:0];
      st.rect_rows = box_rows[6:0];
      return st;
   endfunction

   task automatic reset_shadow();
      for (int i = 0; i < GRID_MAX * GRID_MAX; i++) tile_shadow[i] = '0;
      cfg_width    = GRID_RESET;
      cfg_height   = GRID_RESET;
      cfg_default  = '0;
      dirty_shadow = 1'b1;
      box_left     = 0;
      box_top      = 0;
      box_cols     = GRID_RESET;
      box_rows     = GRID_RESET;
   endtask

   task automatic note_failure(string msg);
      fail_count++;
      if (fail_count <= REPORT_LIMIT) $display("mismatch at %0t: %s", $realtime, msg);
   endtask

   always @(posedge clock) begin : check_result
      tile_status_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_status.size() == 0) begin
            note_failure("result with no item outstanding");
         end else begin
            want = expected_status.pop_front();
            if (rsp_read_value !== want.read_value || rsp_is_dirty !== want.is_dirty ||
                rsp_rect_left !== want.rect_left || rsp_rect_top !== want.rect_top ||
                rsp_rect_cols !== want.rect_cols || rsp_rect_rows !== want.rect_rows)
               note_failure({
                  $sformatf("exp val=%h dirty=%b box=%0d,%0d,%0dx%0d",
                     want.read_value, want.is_dirty, want.rect_left, want.rect_top,
                     want.rect_cols, want.rect_rows),
                  $sformatf(" got val=%h dirty=%b box=%0d,%0d,%0dx%0d",
                     rsp_read_value, rsp_is_dirty, rsp_rect_left, rsp_rect_top,
                     rsp_rect_cols, rsp_rect_rows)});
         end
      end
   end

   always @(negedge clock) rsp_ready = ($urandom_range(0, 99) >= recv_stall_pct);

   // Valid stays high between back-to-back items; drop it only on an idle cycle.
   task automatic send_tile_item(op_type op, logic signed [7:0] col, logic signed [7:0] row,
                                 logic [15:0] tile);
      tile_status_type want;
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_operation = op;
      req_col       = col;
      req_row       = row;
      req_new_tile  = tile;
      req_valid     = 1'b1;
      do @(posedge clock); while (!req_ready);
      want = apply_tile_op(op, col, row, tile);
      expected_status = {expected_status, want};
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_status.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(csr_index_type idx, logic [15:0] value);
      wait_drained();
      @(negedge clock);
      csr_write_en = 1'b1;
      csr_index    = idx;
      csr_wdata    = value;
      @(negedge clock);
      csr_write_en = 1'b0;
      case (idx)
         CSR_GRID_WIDTH:   cfg_width   = value[6:0];
         CSR_GRID_HEIGHT:  cfg_height  = value[6:0];
         CSR_DEFAULT_TILE: cfg_default = value;
         default: ;
      endcase
   endtask

   function automatic logic [7:0] pick_coord(logic [6:0] lim);
      int span;
      span = (lim > GRID_MAX) ? GRID_MAX : int'(lim);
      if (span == 0 || $urandom_range(0, 99) < 12) return 8'($urandom_range(0, 255));
      return 8'($urandom_range(0, span - 1));
   endfunction

   function automatic logic [15:0] pick_tile();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 40) return 16'($urandom_range(0, 3));
      if (roll < 50) return cfg_default;
      return 16'($urandom_range(0, 65535));
   endfunction

   task automatic test_reset_state();
      send_tile_item(OP_READ, 0, 0, 16'h0000);
      send_tile_item(OP_READ, 63, 63, 16'hFFFF);
   endtask

   task automatic test_rectangle_growth();
      send_tile_item(OP_CLEAR, 0, 0, 16'h0000);
      send_tile_item(OP_WRITE, 63, 63, 16'hFFFF);
      send_tile_item(OP_WRITE, 0, 0, 16'h0001);
      send_tile_item(OP_WRITE, 0, 0, 16'h0001);
      send_tile_item(OP_READ, 63, 63, 16'h0000);
      send_tile_item(OP_CLEAR, -1, -1, 16'hFFFF);
      send_tile_item(OP_WRITE, 10, 20, 16'h0005);
      send_tile_item(OP_WRITE, 12, 18, 16'h0000);
      send_tile_item(OP_WRITE, 12, 18, 16'h0007);
   endtask

   task automatic test_out_of_range();
      send_tile_item(OP_WRITE, -1, 5, 16'h1234);
      send_tile_item(OP_WRITE, 64, 0, 16'h1234);
      send_tile_item(OP_WRITE, 0, -128, 16'h1234);
      send_tile_item(OP_WRITE, 127, 127, 16'h1234);
      send_tile_item(OP_READ, -128, 127, 16'h0000);
      send_tile_item(OP_NONE, 5, 5, 16'h0007);
   endtask

   task automatic test_grid_limits();
      write_register(CSR_DEFAULT_TILE, 16'hA5C3);
      write_register(CSR_GRID_WIDTH, 16'd0);
      write_register(CSR_GRID_HEIGHT, 16'd127);
      send_tile_item(OP_WRITE, 0, 0, 16'h0003);
      send_tile_item(OP_READ, 0, 0, 16'h0000);
      // Oversized grid saturates to the store size.
      write_register(CSR_GRID_WIDTH, 16'd127);
      send_tile_item(OP_WRITE, 63, 63, 16'h0002);
      send_tile_item(OP_READ, 64, 64, 16'h0000);
      send_tile_item(OP_READ, 63, 63, 16'h0000);
      write_register(CSR_GRID_WIDTH, 16'd1);
      write_register(CSR_GRID_HEIGHT, 16'd1);
      send_tile_item(OP_WRITE, 1, 0, 16'h0009);
      send_tile_item(OP_READ, 0, 0, 16'h0000);
   endtask

   task automatic test_random_traffic(int count, logic [6:0] width, logic [6:0] height,
                                      logic [15:0] dflt, int send_pct, int recv_pct);
      int     roll;
      op_type op;
      write_register(CSR_GRID_WIDTH, 16'(width));
      write_register(CSR_GRID_HEIGHT, 16'(height));
      write_register(CSR_DEFAULT_TILE, dflt);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      for (int i = 0; i < count; i++) begin
         // Hold off once mid-phase until every result is back.
         if (i == count / 2) wait_drained();
         roll = $urandom_range(0, 99);
         if (roll < 50)      op = OP_WRITE;
         else if (roll < 86) op = OP_READ;
         else if (roll < 94) op = OP_CLEAR;
         else                op = OP_NONE;
         send_tile_item(op, pick_coord(width), pick_coord(height), pick_tile());
      end
      wait_drained();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_operation  = OP_WRITE;
      req_col        = '0;
      req_row        = '0;
      req_new_tile   = '0;
      csr_write_en   = 1'b0;
      csr_index      = CSR_GRID_WIDTH;
      csr_wdata      = '0;
      fail_count     = 0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      reset_shadow();
      repeat (2) @(negedge clock);
      reset = 1'b0;

      test_reset_state();
      test_rectangle_growth();
      test_out_of_range();
      test_grid_limits();
      test_random_traffic(400, 7'd64, 7'd64, 16'($urandom_range(0, 65535)), 0, 0);
      test_random_traffic(350, 7'd13, 7'd7, 16'hFFFF, 65, 0);
      test_random_traffic(350, 7'd1, 7'd64, 16'h0000, 0, 65);
      test_random_traffic(350, 7'd64, 7'd1, 16'($urandom_range(0, 65535)), 28, 28);
      test_random_traffic(300, 7'd100, 7'd127, 16'($urandom_range(0, 65535)), 0, 0);

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #(CLK_PERIOD * RUN_LIMIT_CYCLES);
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
